// ===== rtl/c3z_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3z_pkg
// shared types and constants of the 3x3 rgb correlation core
// ----------------------------------------------------------------------------
package c3z_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int KSIZE      = 3;
  localparam int KTAPS      = KSIZE * KSIZE;
  localparam int NCHAN      = 3;
  localparam int NCOEFF     = NCHAN * KTAPS;
  localparam int PIX_W      = 8 * NCHAN;
  localparam int PROD_W     = 25;
  localparam int SUM_W      = 28;
  localparam int CFGW_W     = 11;
  localparam int CFGH_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic FUNC_COEFF = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] pix_t;

  // one queue entry: either a coefficient load or a pixel with its pending outputs
  typedef struct packed {
    logic                is_coeff;
    logic [4:0]          idx;
    logic [15:0]         val;
    pix_t [KTAPS-1:0]    win;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [3:0]          mask;
  } job_t;

  typedef struct packed {
    logic [CFGW_W-1:0] w;
    logic [CFGH_W-1:0] h;
  } dims_t;

endpackage

// ===== rtl/conv3x3_zero_pad_rgb_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_rgb_core
// streaming 3x3 rgb correlation with zero padding
// ----------------------------------------------------------------------------
// Takes one request per clock unless the queue is full: a kernel coefficient
// load or one raster pixel. Each pixel produces zero to four outputs (one row
// and one column of lag, with flushes at row and frame ends); outputs leave at
// one per clock while out_ready_i is high, so the sustained rate is one pixel
// per clock except on the last row and the last column, where the output port
// (one result a cycle) sets the pace. The path from an accepted request to
// the port runs through intake and line-buffer read, window shift into the
// queue, multiply and sum. A width or height write restarts the frame; the
// kernel is kept.
// ----------------------------------------------------------------------------
module conv3x3_zero_pad_rgb_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [12:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [4:0]            coeff_index_i,
  input  logic signed [15:0]    coeff_value_i,
  input  logic [7:0]            pixel_red_i,
  input  logic [7:0]            pixel_green_i,
  input  logic [7:0]            pixel_blue_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [27:0]    sum_red_o,
  output logic signed [27:0]    sum_green_o,
  output logic signed [27:0]    sum_blue_o,
  output logic [11:0]           out_row_o,
  output logic [9:0]            out_col_o,
  output logic                  frame_last_o
);
  import c3z_pkg::*;

  logic [CFGW_W-1:0] width_q;
  logic [CFGH_W-1:0] height_q;
  dims_t             dims;
  logic              cfg_wr, clr;
  logic              push, full, pop, qv;
  job_t              fjob, qjob;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign clr         = cfg_wr && (cfg_index_i == REG_WIDTH || cfg_index_i == REG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFGW_W'(640);
      height_q <= CFGH_W'(480);
    end else if (cfg_wr) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i[CFGW_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // effective sizes: zero acts as one, oversize is clipped
  always_comb begin
    dims.w = width_q;
    if (width_q == '0) dims.w = CFGW_W'(1);
    else if (width_q > CFGW_W'(MAX_WIDTH)) dims.w = CFGW_W'(MAX_WIDTH);
    dims.h = height_q;
    if (height_q == '0) dims.h = CFGH_W'(1);
    else if (height_q > CFGH_W'(MAX_HEIGHT)) dims.h = CFGH_W'(MAX_HEIGHT);
  end

  c3z_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clr_i        (clr),
    .dims_i       (dims),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .coeff_index_i(coeff_index_i),
    .coeff_value_i(coeff_value_i),
    .pix_i        ({pixel_blue_i, pixel_green_i, pixel_red_i}),
    .push_o       (push),
    .job_o        (fjob),
    .full_i       (full)
  );

  c3z_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (fjob),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(qv),
    .job_o  (qjob)
  );

  c3z_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .valid_i     (qv),
    .job_i       (qjob),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sum_red_o   (sum_red_o),
    .sum_green_o (sum_green_o),
    .sum_blue_o  (sum_blue_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .frame_last_o(frame_last_o)
  );

endmodule

// ===== rtl/c3z_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3z_front
// request intake, raster position, line buffers and 3x3 window
// ----------------------------------------------------------------------------
module c3z_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_i,
  input  c3z_pkg::dims_t           dims_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     func_i,
  input  logic [4:0]               coeff_index_i,
  input  logic signed [15:0]       coeff_value_i,
  input  c3z_pkg::pix_t            pix_i,
  output logic                     push_o,
  output c3z_pkg::job_t            job_o,
  input  logic                     full_i
);
  import c3z_pkg::*;

  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             s1_v_q;
  logic             s1_func_q;
  logic [4:0]       s1_idx_q;
  logic [15:0]      s1_val_q;
  pix_t             s1_pix_q;
  logic [ROW_W-1:0] s1_r_q;
  logic [COL_W-1:0] s1_c_q;
  logic [3:0]       s1_mask_q;
  pix_t             rd0_q, rd1_q, fwd0_q, fwd1_q;
  logic             fwd_q;
  pix_t             e0, e1;
  pix_t [KTAPS-1:0] win_q, win_d;
  pix_t             line0 [MAX_WIDTH];
  pix_t             line1 [MAX_WIDTH];
  logic             acc, wr;
  logic [COL_W-1:0] wlast;
  logic [ROW_W-1:0] hlast;
  logic [3:0]       mask;

  assign wlast = COL_W'(dims_i.w - 1'b1);
  assign hlast = ROW_W'(dims_i.h - 1'b1);

  assign push_o     = s1_v_q && !full_i;
  assign in_ready_o = !s1_v_q || !full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign wr         = push_o && (s1_func_q == FUNC_PIXEL);

  // bypass when the line write and the next read hit the same column
  assign e0 = fwd_q ? fwd0_q : rd0_q;
  assign e1 = fwd_q ? fwd1_q : rd1_q;

  always_comb begin
    mask[0] = (row_q != '0) && (col_q != '0);
    mask[1] = (row_q != '0) && (col_q == wlast);
    mask[2] = (row_q == hlast) && (col_q != '0);
    mask[3] = (row_q == hlast) && (col_q == wlast);
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (clr_i) begin
      row_d = '0;
      col_d = '0;
    end else if (acc && func_i == FUNC_PIXEL) begin
      if (col_q == wlast) begin
        col_d = '0;
        row_d = (row_q == hlast) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_comb begin
    win_d = win_q;
    if (wr) begin
      for (int y = 0; y < KSIZE; y++) begin
        for (int x = 0; x < KSIZE - 1; x++) begin
          win_d[y*KSIZE+x] = win_q[y*KSIZE+x+1];
        end
      end
      win_d[2] = e0;
      win_d[5] = e1;
      win_d[8] = s1_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      s1_v_q <= 1'b0;
      fwd_q  <= 1'b0;
      win_q  <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      win_q <= win_d;
      if (acc) begin
        s1_v_q <= 1'b1;
        fwd_q  <= wr && (s1_c_q == col_q);
      end else if (push_o) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_func_q <= func_i;
      s1_idx_q  <= coeff_index_i;
      s1_val_q  <= coeff_value_i;
      s1_pix_q  <= pix_i;
      s1_r_q    <= row_q;
      s1_c_q    <= col_q;
      s1_mask_q <= mask;
      rd0_q     <= line0[col_q];
      rd1_q     <= line1[col_q];
      fwd0_q    <= e1;
      fwd1_q    <= s1_pix_q;
    end
    if (wr) begin
      line0[s1_c_q] <= e1;
      line1[s1_c_q] <= s1_pix_q;
    end
  end

  always_comb begin
    job_o.is_coeff = (s1_func_q == FUNC_COEFF);
    job_o.idx      = s1_idx_q;
    job_o.val      = s1_val_q;
    job_o.win      = win_d;
    job_o.row      = s1_r_q;
    job_o.col      = s1_c_q;
    job_o.mask     = s1_mask_q;
  end

endmodule

// ===== rtl/c3z_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3z_queue
// short fifo between front and back
// ----------------------------------------------------------------------------
module c3z_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  c3z_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output c3z_pkg::job_t job_o
);
  import c3z_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wp_q, rp_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= job_i;
  end

endmodule

// ===== rtl/c3z_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3z_back
// kernel store, output sequencing, multiply and sum stages
// ----------------------------------------------------------------------------
module c3z_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  c3z_pkg::dims_t            dims_i,
  input  logic                      valid_i,
  input  c3z_pkg::job_t             job_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [27:0]        sum_red_o,
  output logic signed [27:0]        sum_green_o,
  output logic signed [27:0]        sum_blue_o,
  output logic [11:0]               out_row_o,
  output logic [9:0]                out_col_o,
  output logic                      frame_last_o
);
  import c3z_pkg::*;

  logic [15:0]       kern_q [NCOEFF];
  logic [3:0]        pend_q;
  logic              started_q;
  logic [3:0]        cur, rest;
  logic [1:0]        sel;
  logic              en, issue;
  logic              oy, ox;
  logic [ROW_W-1:0]  cr;
  logic [COL_W-1:0]  cc;
  logic [COL_W-1:0]  wlast;
  logic [ROW_W-1:0]  hlast;
  logic signed [PROD_W-1:0] prod [NCHAN][KTAPS];
  logic signed [PROD_W-1:0] prod_q [NCHAN][KTAPS];
  logic              p_v_q;
  logic [ROW_W-1:0]  p_row_q;
  logic [COL_W-1:0]  p_col_q;
  logic              p_last_q;
  logic              o_v_q;
  logic signed [SUM_W-1:0] o_sum_q [NCHAN];
  logic signed [SUM_W-1:0] sum [NCHAN];
  logic [ROW_W-1:0]  o_row_q;
  logic [COL_W-1:0]  o_col_q;
  logic              o_last_q;

  assign wlast = COL_W'(dims_i.w - 1'b1);
  assign hlast = ROW_W'(dims_i.h - 1'b1);
  assign en    = !o_v_q || out_ready_i;

  // walk the pending outputs of the head entry, lowest bit first
  assign cur  = started_q ? pend_q : job_i.mask;
  always_comb begin
    if (cur[0])      sel = 2'd0;
    else if (cur[1]) sel = 2'd1;
    else if (cur[2]) sel = 2'd2;
    else             sel = 2'd3;
  end
  assign rest  = cur & ~(4'b0001 << sel);
  assign issue = en && valid_i && !job_i.is_coeff && (cur != '0);
  assign pop_o = en && valid_i && (job_i.is_coeff || rest == '0);

  assign oy = sel[1];
  assign ox = sel[0];
  assign cr = oy ? job_i.row : job_i.row - 1'b1;
  assign cc = ox ? job_i.col : job_i.col - 1'b1;

  always_comb begin
    logic [2:0] wy, wx;
    logic       ok;
    logic [3:0] t;
    for (int dy = 0; dy < KSIZE; dy++) begin
      for (int dx = 0; dx < KSIZE; dx++) begin
        wy = 3'(dy) + 3'(oy);
        wx = 3'(dx) + 3'(ox);
        ok = (wy < 3'(KSIZE)) && (wx < 3'(KSIZE));
        if (dy == 0 && cr == '0)    ok = 1'b0;
        if (dy == 2 && cr == hlast) ok = 1'b0;
        if (dx == 0 && cc == '0)    ok = 1'b0;
        if (dx == 2 && cc == wlast) ok = 1'b0;
        t = ok ? (4'(wy) * 4'(KSIZE) + 4'(wx)) : 4'd0;
        for (int ch = 0; ch < NCHAN; ch++) begin
          prod[ch][dy*KSIZE+dx] = ok ?
            PROD_W'($signed({1'b0, job_i.win[t][8*ch +: 8]}) *
                    $signed(kern_q[ch*KTAPS + dy*KSIZE + dx])) : '0;
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NCHAN; ch++) begin
      sum[ch] = '0;
      for (int k = 0; k < KTAPS; k++) begin
        sum[ch] = sum[ch] + SUM_W'(prod_q[ch][k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCOEFF; i++) kern_q[i] <= '0;
      started_q <= 1'b0;
      pend_q    <= '0;
      p_v_q     <= 1'b0;
      o_v_q     <= 1'b0;
    end else begin
      if (pop_o) begin
        started_q <= 1'b0;
        if (job_i.is_coeff && job_i.idx < 5'(NCOEFF)) kern_q[job_i.idx] <= job_i.val;
      end else if (issue) begin
        started_q <= 1'b1;
        pend_q    <= rest;
      end
      if (en) begin
        p_v_q <= issue;
        o_v_q <= p_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q   <= prod;
      p_row_q  <= cr;
      p_col_q  <= cc;
      p_last_q <= (cr == hlast) && (cc == wlast);
      o_sum_q  <= sum;
      o_row_q  <= p_row_q;
      o_col_q  <= p_col_q;
      o_last_q <= p_last_q;
    end
  end

  assign out_valid_o  = o_v_q;
  assign sum_red_o    = o_sum_q[0];
  assign sum_green_o  = o_sum_q[1];
  assign sum_blue_o   = o_sum_q[2];
  assign out_row_o    = o_row_q;
  assign out_col_o    = o_col_q;
  assign frame_last_o = o_last_q;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the streaming 3x3 rgb correlation core
// ----------------------------------------------------------------------------
// A behavioral model of the window and line buffers predicts every output
// pixel. Coefficient loads and pixels are sent in bursts with random gaps.
// The output side stalls on a pattern of its own. Each output is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import c3z_pkg::*;

  // one predicted output pixel
  typedef struct packed {
    logic [27:0] red;
    logic [27:0] green;
    logic [27:0] blue;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } outpix_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [12:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        func_i;
  logic [4:0]  coeff_index_i;
  logic signed [15:0] coeff_value_i;
  logic [7:0]  pixel_red_i;
  logic [7:0]  pixel_green_i;
  logic [7:0]  pixel_blue_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic signed [27:0] sum_red_o;
  logic signed [27:0] sum_green_o;
  logic signed [27:0] sum_blue_o;
  logic [11:0] out_row_o;
  logic [9:0]  out_col_o;
  logic        frame_last_o;

  conv3x3_zero_pad_rgb_core dut (.*);

  // model state
  logic [10:0]      img_w_reg;
  logic [12:0]      img_h_reg;
  logic signed [15:0] kern [NCOEFF];
  logic [23:0]      line_mem [2*MAX_WIDTH];
  logic [23:0]      win [KTAPS];
  int               next_row;
  int               next_col;

  outpix_t pending_q [$];
  int      err_cnt;
  bit      stall_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int eff_w();
    int w;
    w = int'(img_w_reg);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_h();
    int h;
    h = int'(img_h_reg);
    if (h == 0) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  // window cell (0,0) sits at image (r0,c0); taps outside the image are zero
  function automatic outpix_t window_sum(int cr, int cc, int r0, int c0, int w, int h);
    outpix_t o;
    int acc [3];
    int ir, ic, pix;
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = 0;
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          ir = cr - 1 + dy;
          ic = cc - 1 + dx;
          if (ir >= 0 && ir < h && ic >= 0 && ic < w &&
              ir - r0 >= 0 && ir - r0 < 3 && ic - c0 >= 0 && ic - c0 < 3) begin
            pix = int'((win[(ir - r0) * 3 + ic - c0] >> (8 * ch)) & 24'hff);
            acc[ch] += pix * int'(kern[ch * 9 + dy * 3 + dx]);
          end
        end
      end
    end
    o.red   = acc[0][27:0];
    o.green = acc[1][27:0];
    o.blue  = acc[2][27:0];
    o.row   = cr[11:0];
    o.col   = cc[9:0];
    o.last  = (cr == h - 1 && cc == w - 1);
    return o;
  endfunction

  // advance the model by one accepted request
  task automatic predict_request(bit fn, logic [4:0] idx, logic [15:0] val,
                                 logic [7:0] rd, logic [7:0] gn, logic [7:0] bl);
    int w, h, r, c;
    logic [23:0] pix;
    w = eff_w();
    h = eff_h();
    if (fn == FUNC_COEFF) begin
      if (idx < NCOEFF) kern[idx] = val;
      return;
    end
    r = next_row;
    c = next_col;
    if (r >= h) r = h - 1;
    if (c >= w) c = w - 1;
    pix = {bl, gn, rd};
    for (int y = 0; y < 3; y++) begin
      win[y * 3]     = win[y * 3 + 1];
      win[y * 3 + 1] = win[y * 3 + 2];
    end
    win[2] = line_mem[c];
    win[5] = line_mem[MAX_WIDTH + c];
    win[8] = pix;
    line_mem[c] = line_mem[MAX_WIDTH + c];
    line_mem[MAX_WIDTH + c] = pix;
    if (r >= 1) begin
      if (c >= 1) pending_q.push_back(window_sum(r - 1, c - 1, r - 2, c - 2, w, h));
      if (c == w - 1) pending_q.push_back(window_sum(r - 1, c, r - 2, c - 2, w, h));
    end
    if (r == h - 1) begin
      if (c >= 1) pending_q.push_back(window_sum(r, c - 1, r - 2, c - 2, w, h));
      if (c == w - 1) pending_q.push_back(window_sum(r, c, r - 2, c - 2, w, h));
    end
    if (c == w - 1) begin
      next_col = 0;
      next_row = (r == h - 1) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
      next_row = r;
    end
  endtask

  // send one request, sometimes with a random gap ahead of it
  task automatic send_request(bit fn, logic [4:0] idx, logic [15:0] val,
                              logic [7:0] rd, logic [7:0] gn, logic [7:0] bl);
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 6)) @(negedge clk_i);
    in_valid_i    <= 1'b1;
    func_i        <= fn;
    coeff_index_i <= idx;
    coeff_value_i <= val;
    pixel_red_i   <= rd;
    pixel_green_i <= gn;
    pixel_blue_i  <= bl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_request(fn, idx, val, rd, gn, bl);
    @(negedge clk_i);
    // blocking, so a request that follows at this same edge may raise valid again
    in_valid_i = 1'b0;
  endtask

  task automatic send_pixel(logic [7:0] rd, logic [7:0] gn, logic [7:0] bl);
    send_request(FUNC_PIXEL, 5'd0, 16'd0, rd, gn, bl);
  endtask

  task automatic send_coeff(logic [4:0] idx, logic [15:0] val);
    send_request(FUNC_COEFF, idx, val, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // wait for every prediction to drain, then a quiet margin
  task automatic wait_drained();
    int guard;
    guard = 0;
    while (pending_q.size() != 0 && guard < 200_000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_WIDTH) img_w_reg = val[10:0];
    else img_h_reg = val;
    next_row = 0;
    next_col = 0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_dims(int w, int h);
    write_reg(REG_WIDTH, w[12:0]);
    write_reg(REG_HEIGHT, h[12:0]);
  endtask

  task automatic send_frame(int w, int h);
    for (int i = 0; i < w * h; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // directed: extreme coefficients and pixels, ignored index, tiny frames
  task automatic test_directed();
    set_dims(3, 3);
    for (int i = 0; i < 9; i++) send_coeff(5'(i), (i % 2) ? 16'h8000 : 16'h7fff);
    send_coeff(5'd31, 16'h1234);  // out-of-range index is dropped
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'h00, 8'hff, 8'h00);
    for (int i = 0; i < 7; i++) send_pixel(8'hff, 8'hff, 8'hff);
    set_dims(1, 1);
    send_pixel(8'hff, 8'h80, 8'h01);
    set_dims(0, 0);               // zero is taken as one
    send_pixel(8'h7f, 8'hff, 8'h00);
  endtask

  // kernel with random values on all channels, then random frames
  task automatic test_random_kernel_frames();
    for (int i = 0; i < NCOEFF; i++) send_coeff(5'(i), 16'($urandom));
    set_dims(4, 3);
    send_frame(4, 3);
    set_dims(2, 5);
    send_frame(2, 5);
    set_dims(5, 1);
    send_frame(5, 1);
  endtask

  // mixed stream: coefficient reloads between pixels, partial frame cut by a write
  task automatic test_mixed_stream();
    set_dims($urandom_range(2, 6), $urandom_range(2, 5));
    for (int i = 0; i < 30; i++) begin
      if ($urandom_range(0, 7) == 0) send_coeff(5'($urandom_range(0, 31)), 16'($urandom));
      else send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
    set_dims(3, 2);
    send_frame(3, 2);
  endtask

  // width above the limit clamps; the largest height settings
  task automatic test_extreme_dims();
    write_reg(REG_WIDTH, 13'd2047);
    write_reg(REG_HEIGHT, 13'd2);
    send_frame(2, 1);              // partial frame, no output until flush rows
    set_dims(1, 8191);             // clamped to the tallest frame
    for (int i = 0; i < 4; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    set_dims(3, 3);
    send_frame(3, 3);
  endtask

  // output side: stall on a pattern with quiet stretches
  initial begin
    out_ready_i = 1'b0;
    stall_on = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 31) == 0) stall_on = ~stall_on;
      out_ready_i <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
    end
  end

  // compare every accepted output with the oldest prediction
  initial begin
    outpix_t exp_px;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_q.size() == 0) begin
          $display("%0t unexpected output row %0d col %0d", $time, out_row_o, out_col_o);
          err_cnt++;
        end else begin
          exp_px = pending_q.pop_front();
          if (exp_px.red !== sum_red_o || exp_px.green !== sum_green_o ||
              exp_px.blue !== sum_blue_o || exp_px.row !== out_row_o ||
              exp_px.col !== out_col_o || exp_px.last !== frame_last_o) begin
            $display("%0t mismatch exp %h %h %h r%0d c%0d l%0d got %h %h %h r%0d c%0d l%0d",
                     $time, exp_px.red, exp_px.green, exp_px.blue, exp_px.row,
                     exp_px.col, exp_px.last, sum_red_o, sum_green_o, sum_blue_o,
                     out_row_o, out_col_o, frame_last_o);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    err_cnt = 0;
    img_w_reg = 11'd640;
    img_h_reg = 13'd480;
    next_row = 0;
    next_col = 0;
    for (int i = 0; i < NCOEFF; i++) kern[i] = '0;
    for (int i = 0; i < 2 * MAX_WIDTH; i++) line_mem[i] = '0;
    for (int i = 0; i < KTAPS; i++) win[i] = '0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    func_i = FUNC_PIXEL;
    coeff_index_i = '0;
    coeff_value_i = '0;
    pixel_red_i = '0;
    pixel_green_i = '0;
    pixel_blue_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    test_directed();
    test_random_kernel_frames();
    test_mixed_stream();
    test_extreme_dims();
    wait_drained();
    if (pending_q.size() != 0) begin
      $display("%0t %0d outputs never arrived", $time, pending_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
